// ----- rtl/core/wa_pkg.sv -----
package wa_pkg;

  localparam int OPERAND_BYTES = 32;
  localparam int OPERAND_W     = 8 * OPERAND_BYTES;
  localparam int IN_DATA_W     = 2 * OPERAND_W;
  localparam int OUT_DATA_W    = ((OPERAND_W + 2 + 7) / 8) * 8;

  typedef enum logic [1:0] {
    FUNC_CMP = 2'd0,
    FUNC_ADD = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_NEG = 2'd3
  } func_t;

  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_LT = 2'b11;

  typedef struct packed {
    func_t                func;
    logic [OPERAND_W-1:0] a;
    logic [OPERAND_W-1:0] b;
    logic [OPERAND_W-1:0] acc;
    logic [1:0]           ord;
  } stage_t;

endpackage

// ----- rtl/core/wa_front.sv -----
module wa_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  wa_pkg::stage_t st_i,
  output logic           ready_o,
  output logic           valid_o,
  output wa_pkg::stage_t st_o,
  input  logic           ready_i
);

  logic           valid_r, valid_nxt;
  wa_pkg::stage_t st_r, st_nxt;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    st_nxt      = st_i;
    st_nxt.acc  = '0;
    st_nxt.ord  = wa_pkg::ORD_EQ;
    case (st_i.func)
      wa_pkg::FUNC_CMP: begin
        if (st_i.a > st_i.b) begin
          st_nxt.ord = wa_pkg::ORD_GT;
        end else if (st_i.a < st_i.b) begin
          st_nxt.ord = wa_pkg::ORD_LT;
        end
      end
      wa_pkg::FUNC_ADD: st_nxt.acc = st_i.a + st_i.b;
      wa_pkg::FUNC_NEG: st_nxt.acc = (~st_i.a) + wa_pkg::OPERAND_W'(1);
      default:          st_nxt.acc = '0;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ready_o) begin
      valid_nxt = valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      st_r <= st_nxt;
    end
  end

  assign valid_o = valid_r;
  assign st_o    = st_r;

endmodule

// ----- rtl/core/wa_mul_cell.sv -----
module wa_mul_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  wa_pkg::stage_t st_i,
  output logic           ready_o,
  output logic           valid_o,
  output wa_pkg::stage_t st_o,
  input  logic           ready_i
);

  localparam int LANES = wa_pkg::OPERAND_BYTES;

  logic           valid_r, valid_nxt;
  wa_pkg::stage_t st_r, st_nxt;
  logic [15:0]    lane_prod [LANES];
  logic [wa_pkg::OPERAND_W-1:0] even_w;
  logic [wa_pkg::OPERAND_W+7:0] odd_w;

  assign ready_o = !valid_r || ready_i;

  // one byte of a against every byte of b; no two even lanes overlap, nor two odd lanes
  always_comb begin
    even_w = '0;
    odd_w  = '0;
    for (int j = 0; j < LANES; j++) begin
      lane_prod[j] = st_i.a[7:0] * st_i.b[8*j +: 8];
      if ((j % 2) == 0) begin
        even_w[8*j +: 16] = lane_prod[j];
      end else begin
        odd_w[8*j +: 16] = lane_prod[j];
      end
    end
  end

  always_comb begin
    st_nxt   = st_i;
    st_nxt.a = st_i.a >> 8;
    st_nxt.b = st_i.b << 8;
    if (st_i.func == wa_pkg::FUNC_MUL) begin
      st_nxt.acc = st_i.acc + even_w + odd_w[wa_pkg::OPERAND_W-1:0];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ready_o) begin
      valid_nxt = valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      st_r <= st_nxt;
    end
  end

  assign valid_o = valid_r;
  assign st_o    = st_r;

endmodule

// ----- rtl/core/wide_256bit_alu_unit.sv -----
// 256-bit unsigned alu: compare, add, multiply (low 256 bits) and negate of a.
// every word passes a front stage (add, negate, compare) and then a chain of
// 32 multiply cells, each folding one byte of a into the running product.
// a new word can enter every cycle; each stage stalls only when the stage
// after it is full and stalled, and the last cell is the output register.
module wide_256bit_alu_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wa_pkg::IN_DATA_W-1:0]  in_tdata,   // operand_a_w0..w3, operand_b_w0..w3
  input  logic [1:0]                    in_tuser,   // func
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wa_pkg::OUT_DATA_W-1:0] out_tdata   // result_w0..w3, order, zero pad
);

  localparam int NSTG = wa_pkg::OPERAND_BYTES + 2;

  wa_pkg::stage_t st  [NSTG];
  logic           vld [NSTG];
  logic           rdy [NSTG];

  always_comb begin
    st[0]      = '0;
    st[0].func = wa_pkg::func_t'(in_tuser);
    st[0].a    = in_tdata[wa_pkg::OPERAND_W-1:0];
    st[0].b    = in_tdata[wa_pkg::IN_DATA_W-1:wa_pkg::OPERAND_W];
  end

  assign vld[0]    = in_tvalid;
  assign in_tready = rdy[0];

  wa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vld[0]),
    .st_i    (st[0]),
    .ready_o (rdy[0]),
    .valid_o (vld[1]),
    .st_o    (st[1]),
    .ready_i (rdy[1])
  );

  for (genvar k = 1; k < NSTG - 1; k++) begin : g_mul
    wa_mul_cell u_mul (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld[k]),
      .st_i    (st[k]),
      .ready_o (rdy[k]),
      .valid_o (vld[k+1]),
      .st_o    (st[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  assign rdy[NSTG-1] = out_tready;
  assign out_tvalid  = vld[NSTG-1];
  assign out_tdata   = wa_pkg::OUT_DATA_W'({st[NSTG-1].ord, st[NSTG-1].acc});

endmodule

// ----- dv/wide_256bit_alu_unit_tb.sv -----
`timescale 1ns / 1ps

module wide_256bit_alu_unit_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [wa_pkg::OPERAND_W-1:0] operand_t;

  typedef struct {
    operand_t   value;
    logic [1:0] ord;
  } alu_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [wa_pkg::IN_DATA_W-1:0]  in_tdata;   // operand_a_w0..w3, operand_b_w0..w3
  logic [1:0]                    in_tuser;   // func
  logic                          out_tvalid;
  logic                          out_tready;
  logic [wa_pkg::OUT_DATA_W-1:0] out_tdata;  // result_w0..w3, order, zero pad

  alu_result_t expected_results[$];
  int          error_count;
  int          results_seen;
  int          func_count[4];
  int          cycle_count;
  int          burst_left;
  bit          gaps_enabled;
  bit          hold_req;
  bit          rx_always_ready;

  wide_256bit_alu_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alu_result_t alu_predict(wa_pkg::func_t f, operand_t a, operand_t b);
    alu_result_t r;
    r.value = '0;
    r.ord   = wa_pkg::ORD_EQ;
    case (f)
      wa_pkg::FUNC_CMP: begin
        if (a > b) r.ord = wa_pkg::ORD_GT;
        else if (a < b) r.ord = wa_pkg::ORD_LT;
      end
      wa_pkg::FUNC_ADD: r.value = a + b;
      wa_pkg::FUNC_MUL: r.value = a * b;   // 256-bit context keeps the low half
      default:          r.value = operand_t'(0) - a;
    endcase
    return r;
  endfunction

  function automatic operand_t rand_operand();
    operand_t v;
    v = '0;
    case ($urandom_range(0, 5))
      0, 1: for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom();
      2: v[31:0] = $urandom();
      3: begin
        v = '1;
        v[$urandom_range(0, 3)*64 +: 64] = {$urandom(), $urandom()};
      end
      4: v[$urandom_range(0, wa_pkg::OPERAND_W-1)] = 1'b1;
      default: for (int i = 0; i < wa_pkg::OPERAND_BYTES; i++)
        v[i*8 +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
    endcase
    return v;
  endfunction

  // predictions are taken at the input handshake
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(alu_predict(wa_pkg::func_t'(in_tuser),
                                             in_tdata[wa_pkg::OPERAND_W-1:0],
                                             in_tdata[wa_pkg::IN_DATA_W-1:wa_pkg::OPERAND_W]));
      func_count[in_tuser]++;
    end
  end

  always @(posedge clk) begin : result_check
    alu_result_t want;
    operand_t    got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[wa_pkg::OPERAND_W-1:0];
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        for (int w = 0; w < 4; w++) begin
          if (got[w*64 +: 64] !== want.value[w*64 +: 64]) begin
            $error("result_w%0d: expected %h, got %h", w,
                   want.value[w*64 +: 64], got[w*64 +: 64]);
            error_count++;
          end
        end
        if (out_tdata[wa_pkg::OPERAND_W +: 2] !== want.ord) begin
          $error("order: expected %b, got %b", want.ord,
                 out_tdata[wa_pkg::OPERAND_W +: 2]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: segments of different stall patterns, plus a long hold-off on request
  initial begin : receiver
    int mode;
    int seg;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 80);
      repeat (seg) begin
        @(negedge clk);
        if (hold_req) begin
          for (int n = 0; n < HOLD_CYCLES; n++) begin
            out_tready = 1'b0;
            @(negedge clk);
          end
          hold_req = 1'b0;
        end
        if (rx_always_ready) out_tready = 1'b1;
        else begin
          case (mode)
            0:       out_tready = 1'b1;
            1:       out_tready = ($urandom_range(0, 1) == 1);
            2:       out_tready = ($urandom_range(0, 9) != 0);
            default: out_tready = ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(wa_pkg::func_t f, operand_t a, operand_t b);
    in_tvalid = 1'b1;
    in_tdata  = {b, a};
    in_tuser  = f;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_for_results();
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    operand_t ones;
    operand_t top_bit;
    ones    = '1;
    top_bit = operand_t'(1) << (wa_pkg::OPERAND_W - 1);
    send_word(wa_pkg::FUNC_CMP, '0, '0);
    send_word(wa_pkg::FUNC_CMP, ones, ones);
    send_word(wa_pkg::FUNC_CMP, '0, ones);
    send_word(wa_pkg::FUNC_CMP, ones, '0);
    send_word(wa_pkg::FUNC_CMP, top_bit, ones >> 1);
    send_word(wa_pkg::FUNC_CMP, operand_t'(2), operand_t'(3));
    send_word(wa_pkg::FUNC_CMP, {64'h1, 192'h0}, {64'h1, 191'h0, 1'b1});
    send_word(wa_pkg::FUNC_ADD, '0, '0);
    send_word(wa_pkg::FUNC_ADD, ones, operand_t'(1));
    send_word(wa_pkg::FUNC_ADD, ones, ones);
    send_word(wa_pkg::FUNC_ADD, {192'h0, 64'hffff_ffff_ffff_ffff}, operand_t'(1));
    send_word(wa_pkg::FUNC_ADD, {4{64'haaaa_aaaa_aaaa_aaaa}},
              {4{64'h5555_5555_5555_5555}});
    send_word(wa_pkg::FUNC_MUL, '0, ones);
    send_word(wa_pkg::FUNC_MUL, ones, ones);
    send_word(wa_pkg::FUNC_MUL, operand_t'(1), rand_operand());
    send_word(wa_pkg::FUNC_MUL, operand_t'(1) << 128, operand_t'(1) << 128);
    send_word(wa_pkg::FUNC_MUL, {192'h0, 64'hffff_ffff_ffff_ffff},
              {192'h0, 64'hffff_ffff_ffff_ffff});
    send_word(wa_pkg::FUNC_MUL, {4{64'h0123_4567_89ab_cdef}},
              {4{64'hfedc_ba98_7654_3210}});
    send_word(wa_pkg::FUNC_NEG, '0, ones);
    send_word(wa_pkg::FUNC_NEG, operand_t'(1), ones);
    send_word(wa_pkg::FUNC_NEG, ones, '0);
    send_word(wa_pkg::FUNC_NEG, top_bit, rand_operand());
    send_word(wa_pkg::FUNC_NEG, {4{64'haaaa_aaaa_aaaa_aaaa}}, rand_operand());
    wait_for_results();
  endtask

  task automatic test_random(int count);
    wa_pkg::func_t f;
    operand_t      a;
    operand_t      b;
    for (int i = 0; i < count; i++) begin
      f = wa_pkg::func_t'($urandom_range(0, 3));
      a = rand_operand();
      b = rand_operand();
      // compare needs equal and near-equal pairs to reach every outcome
      if (f == wa_pkg::FUNC_CMP) begin
        case ($urandom_range(0, 3))
          0: b = a;
          1: begin
            b = a;
            b[$urandom_range(0, wa_pkg::OPERAND_W-1)] ^= 1'b1;
          end
          default: ;
        endcase
      end
      send_word(f, a, b);
      if (i % 300 == 299) wait_for_results();
    end
    wait_for_results();
  endtask

  // output held off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure(int count);
    hold_req = 1'b1;
    for (int i = 0; i < count; i++)
      send_word(wa_pkg::func_t'($urandom_range(0, 3)), rand_operand(), rand_operand());
    wait_for_results();
  endtask

  task automatic test_full_rate(int count);
    gaps_enabled    = 1'b0;
    rx_always_ready = 1'b1;
    for (int i = 0; i < count; i++)
      send_word(wa_pkg::func_t'($urandom_range(0, 3)), rand_operand(), rand_operand());
    wait_for_results();
    gaps_enabled    = 1'b1;
    rx_always_ready = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = wa_pkg::FUNC_CMP;
    error_count     = 0;
    results_seen    = 0;
    cycle_count     = 0;
    burst_left      = 0;
    gaps_enabled    = 1'b1;
    hold_req        = 1'b0;
    rx_always_ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random(900);
    test_backpressure(90);
    test_full_rate(140);

    wait_for_results();
    repeat (40) @(negedge clk);

    $display("checked %0d results: %0d compare, %0d add, %0d multiply, %0d negate",
             results_seen, func_count[wa_pkg::FUNC_CMP], func_count[wa_pkg::FUNC_ADD],
             func_count[wa_pkg::FUNC_MUL], func_count[wa_pkg::FUNC_NEG]);
    $display("traffic mixed sender gaps, receiver stalls, a long hold-off and full rate");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/wa_pkg.sv
rtl/core/wa_front.sv
rtl/core/wa_mul_cell.sv
rtl/core/wide_256bit_alu_unit.sv
dv/wide_256bit_alu_unit_tb.sv
